@@ rtl/core/priority_timed_line_queue_assert.svh @@
// ---------------------------------------------------------------------------
// priority_timed_line_queue assertion macros
// Shared property wrappers, clocked on clk and disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef PRIORITY_TIMED_LINE_QUEUE_ASSERT_SVH
`define PRIORITY_TIMED_LINE_QUEUE_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define PTLQ_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define PTLQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/ptlq_pkg.sv @@
// ---------------------------------------------------------------------------
// ptlq_pkg
// Sizes, opcodes and controller/datapath handshake types of the queue.
// ---------------------------------------------------------------------------
package ptlq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int NUM_CLASSES = 4;
  localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int TOT_W       = $clog2(NUM_CLASSES * QUEUE_DEPTH + 1);
  localparam int STORE_DEPTH = NUM_CLASSES * QUEUE_DEPTH;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int WORD_W      = 32;
  localparam int TIME_W      = 16;
  localparam int AGE_W       = 17;

  localparam logic [TIME_W-1:0] DEFAULT_DURATION_RST = 16'd640;

  localparam logic [1:0] OP_PUSH  = 2'd0;
  localparam logic [1:0] OP_TICK  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam int CFG_AW = 3;

  typedef struct packed {
    logic latch;     // capture input word
    logic exec;      // run push / tick start / clear
    logic rd_start;  // read head of class being drained
    logic pop;       // pop head if aged out
    logic tick_end;  // tick wrap-up, age clear check
    logic rd_top;    // read head of served class
    logic load_out;  // load result register
  } ptlq_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       empty;
    logic       pop_ok;
  } ptlq_sts_t;

endpackage

@@ rtl/core/ptlq_in_if.sv @@
// ---------------------------------------------------------------------------
// ptlq_in_if
// Input channel: valid/ready with the operation word.
// ---------------------------------------------------------------------------
interface ptlq_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [1:0]  class_sel;
  logic [15:0] entry_tag;
  logic [15:0] entry_duration;
  logic [15:0] elapsed;

  modport source (output valid, opcode, class_sel, entry_tag, entry_duration, elapsed,
                  input ready);
  modport sink (input valid, opcode, class_sel, entry_tag, entry_duration, elapsed,
                output ready);
endinterface

@@ rtl/core/ptlq_out_if.sv @@
// ---------------------------------------------------------------------------
// ptlq_out_if
// Result channel: valid/ready with the status word.
// ---------------------------------------------------------------------------
interface ptlq_out_if;
  logic        valid;
  logic        ready;
  logic        has_entry;
  logic        blocking;
  logic [1:0]  served_class;
  logic [15:0] head_tag;
  logic [15:0] head_duration;
  logic [6:0]  total_queued;
  logic        dropped;
  logic [4:0]  finished_count;

  modport source (output valid, has_entry, blocking, served_class, head_tag,
                  head_duration, total_queued, dropped, finished_count,
                  input ready);
  modport sink (input valid, has_entry, blocking, served_class, head_tag,
                head_duration, total_queued, dropped, finished_count,
                output ready);
endinterface

@@ rtl/core/ptlq_ram.sv @@
// ---------------------------------------------------------------------------
// ptlq_ram
// Simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module ptlq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/core/ptlq_datapath.sv @@
// ---------------------------------------------------------------------------
// ptlq_datapath
// Queue pointers, counts, age, entry store and result register.
// ---------------------------------------------------------------------------
module ptlq_datapath import ptlq_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  ptlq_cmd_t         cmd,
  output ptlq_sts_t         sts,
  input  logic              cfg_we,
  input  logic [TIME_W-1:0] cfg_wdata,
  output logic [TIME_W-1:0] dflt_dur,
  input  logic [1:0]        in_opcode,
  input  logic [1:0]        in_class_sel,
  input  logic [15:0]       in_entry_tag,
  input  logic [15:0]       in_entry_duration,
  input  logic [15:0]       in_elapsed,
  output logic              out_has_entry,
  output logic              out_blocking,
  output logic [1:0]        out_served_class,
  output logic [15:0]       out_head_tag,
  output logic [15:0]       out_head_duration,
  output logic [6:0]        out_total_queued,
  output logic              out_dropped,
  output logic [4:0]        out_finished_count
);

  logic [PTR_W-1:0]  head_r [NUM_CLASSES];
  logic [CNT_W-1:0]  cnt_r  [NUM_CLASSES];
  logic [AGE_W-1:0]  age_r;
  logic [TIME_W-1:0] dflt_r;
  logic [1:0]        op_r, cls_r, start_r;
  logic [15:0]       tag_r, dur_r, elap_r;
  logic              drop_r;
  logic [CNT_W-1:0]  fin_r;

  logic              res_has_r, res_blk_r, res_drop_r;
  logic [1:0]        res_cls_r;
  logic [15:0]       res_tag_r, res_dur_r;
  logic [6:0]        res_tot_r;
  logic [4:0]        res_fin_r;

  logic [TOT_W-1:0]  total;
  logic [1:0]        top;
  logic              empty;
  logic [WORD_W-1:0] rdata;
  logic [ADDR_W-1:0] waddr, raddr;
  logic              re, we;
  logic [PTR_W:0]    wpos;
  logic [15:0]       dur_eff;
  logic              pop_ok;
  logic [PTR_W-1:0]  head_inc;

  function automatic logic [ADDR_W-1:0] slot_addr(input logic [1:0] c,
                                                  input logic [PTR_W-1:0] p);
    return ADDR_W'(c) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(p);
  endfunction

  always_comb begin
    total = '0;
    for (int i = 0; i < NUM_CLASSES; i++) begin
      total = total + TOT_W'(cnt_r[i]);
    end
    if (cnt_r[3] != '0) begin
      top = 2'd3;
    end else if (cnt_r[2] != '0) begin
      top = 2'd2;
    end else if (cnt_r[1] != '0) begin
      top = 2'd1;
    end else begin
      top = 2'd0;
    end
  end

  assign empty   = (total == '0);
  assign dur_eff = (dur_r == '0) ? dflt_r : dur_r;
  assign wpos    = (PTR_W+1)'(head_r[cls_r]) + (PTR_W+1)'(cnt_r[cls_r]);
  assign waddr   = slot_addr(cls_r, (wpos >= (PTR_W+1)'(QUEUE_DEPTH)) ?
                             PTR_W'(wpos - (PTR_W+1)'(QUEUE_DEPTH)) : PTR_W'(wpos));
  assign we      = cmd.exec && (op_r == OP_PUSH) &&
                   (cnt_r[cls_r] != CNT_W'(QUEUE_DEPTH));
  assign re      = cmd.rd_start || cmd.rd_top;
  assign raddr   = cmd.rd_start ? slot_addr(start_r, head_r[start_r]) :
                                  slot_addr(top, head_r[top]);
  assign pop_ok  = (cnt_r[start_r] != '0) && (age_r >= {1'b0, rdata[15:0]});
  assign head_inc = (head_r[start_r] == PTR_W'(QUEUE_DEPTH - 1)) ? '0 :
                    head_r[start_r] + 1'b1;

  ptlq_ram #(.WIDTH(WORD_W), .DEPTH(STORE_DEPTH)) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata ({tag_r, dur_eff}),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CLASSES; i++) begin
        head_r[i] <= '0;
        cnt_r[i]  <= '0;
      end
      age_r  <= '0;
      dflt_r <= DEFAULT_DURATION_RST;
    end else begin
      if (cfg_we) begin
        dflt_r <= (cfg_wdata == '0) ? TIME_W'(1) : cfg_wdata;
      end
      if (cmd.exec) begin
        case (op_r)
          OP_PUSH: begin
            if (we) begin
              cnt_r[cls_r] <= cnt_r[cls_r] + 1'b1;
            end
          end
          OP_TICK: begin
            if (empty) begin
              age_r <= '0;
            end else begin
              age_r <= age_r + {1'b0, elap_r};
            end
          end
          OP_CLEAR: begin
            for (int i = 0; i < NUM_CLASSES; i++) begin
              head_r[i] <= '0;
              cnt_r[i]  <= '0;
            end
            age_r <= '0;
          end
          default: begin
          end
        endcase
      end
      if (cmd.pop && pop_ok) begin
        age_r           <= age_r - {1'b0, rdata[15:0]};
        head_r[start_r] <= head_inc;
        cnt_r[start_r]  <= cnt_r[start_r] - 1'b1;
      end
      if (cmd.tick_end && (empty || (top != start_r))) begin
        age_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r   <= in_opcode;
      cls_r  <= in_class_sel;
      tag_r  <= in_entry_tag;
      dur_r  <= in_entry_duration;
      elap_r <= in_elapsed;
      drop_r <= 1'b0;
      fin_r  <= '0;
    end
    if (cmd.exec) begin
      start_r <= top;
      if (op_r == OP_PUSH && !we) begin
        drop_r <= 1'b1;
      end
    end
    if (cmd.pop && pop_ok) begin
      fin_r <= fin_r + 1'b1;
    end
    if (cmd.load_out) begin
      res_has_r  <= !empty;
      res_blk_r  <= !empty && top[1];
      res_cls_r  <= top;
      res_tag_r  <= empty ? '0 : rdata[31:16];
      res_dur_r  <= empty ? '0 : rdata[15:0];
      res_tot_r  <= 7'(total);
      res_drop_r <= drop_r;
      res_fin_r  <= 5'(fin_r);
    end
  end

  assign sts.op     = op_r;
  assign sts.empty  = empty;
  assign sts.pop_ok = pop_ok;
  assign dflt_dur   = dflt_r;

  assign out_has_entry      = res_has_r;
  assign out_blocking       = res_blk_r;
  assign out_served_class   = res_cls_r;
  assign out_head_tag       = res_tag_r;
  assign out_head_duration  = res_dur_r;
  assign out_total_queued   = res_tot_r;
  assign out_dropped        = res_drop_r;
  assign out_finished_count = res_fin_r;

endmodule

@@ rtl/core/ptlq_ctrl.sv @@
// ---------------------------------------------------------------------------
// ptlq_ctrl
// Sequencer: accept, execute, drain loop, status read, result handoff.
// ---------------------------------------------------------------------------
module ptlq_ctrl import ptlq_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  ptlq_sts_t sts,
  output ptlq_cmd_t cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_CMP  = 3'd3;
  localparam logic [2:0] S_STAT = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (sts.op == OP_TICK && !sts.empty) begin
          state_nxt = S_RD;
        end else begin
          state_nxt = S_STAT;
        end
      end
      S_RD: begin
        cmd.rd_start = 1'b1;
        state_nxt    = S_CMP;
      end
      S_CMP: begin
        if (sts.pop_ok) begin
          cmd.pop   = 1'b1;
          state_nxt = S_RD;
        end else begin
          cmd.tick_end = 1'b1;
          state_nxt    = S_STAT;
        end
      end
      S_STAT: begin
        cmd.rd_top = 1'b1;
        state_nxt  = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

@@ rtl/core/priority_timed_line_queue.sv @@
// ---------------------------------------------------------------------------
// priority_timed_line_queue
// Four strict-priority FIFOs of timed entries with tick-driven expiry.
//
//   port     dir  kind        carries
//   in_if    in   valid/ready push / tick / clear word
//   out_if   out  valid/ready status word, one per input word
//   cfg_*    in   APB         default_duration at byte 0
//
// Push, clear and a tick on empty queues go from accept through execute and
// status read to the result load. Other ticks add a drain loop after execute:
// one RAM read and compare per pop, plus one for the head that stops the drain.
// Reset (rst_n low, synchronous) empties all queues and sets the default
// duration to 640. A stalled result holds the sequencer in its last step.
// ---------------------------------------------------------------------------
`include "priority_timed_line_queue_assert.svh"

module priority_timed_line_queue import ptlq_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  ptlq_in_if.sink           in_if,
  ptlq_out_if.source        out_if,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  ptlq_cmd_t         cmd;
  ptlq_sts_t         sts;
  logic              cfg_we;
  logic [TIME_W-1:0] dflt_dur;

  logic              in_acc;
  logic              out_empty_word;
  logic              out_zero_head;
  logic              out_blk_word;
  logic              out_blk_ok;
  logic              out_drop_word;
  logic              out_no_fin;

  assign cfg_pready = 1'b1;
  assign cfg_we     = cfg_psel && cfg_penable && cfg_pwrite && !cfg_paddr[2];
  assign cfg_prdata = cfg_paddr[2] ? 32'd0 : {16'd0, dflt_dur};

  ptlq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ptlq_datapath u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_pwdata[15:0]),
    .dflt_dur           (dflt_dur),
    .in_opcode          (in_if.opcode),
    .in_class_sel       (in_if.class_sel),
    .in_entry_tag       (in_if.entry_tag),
    .in_entry_duration  (in_if.entry_duration),
    .in_elapsed         (in_if.elapsed),
    .out_has_entry      (out_if.has_entry),
    .out_blocking       (out_if.blocking),
    .out_served_class   (out_if.served_class),
    .out_head_tag       (out_if.head_tag),
    .out_head_duration  (out_if.head_duration),
    .out_total_queued   (out_if.total_queued),
    .out_dropped        (out_if.dropped),
    .out_finished_count (out_if.finished_count)
  );

  assign in_acc         = in_if.valid && in_if.ready;
  assign out_empty_word = out_if.valid && !out_if.has_entry;
  assign out_zero_head  = (out_if.served_class == 2'd0) && (out_if.head_tag == 16'd0) &&
                          (out_if.head_duration == 16'd0);
  assign out_blk_word   = out_if.valid && out_if.blocking;
  assign out_blk_ok     = out_if.has_entry && out_if.served_class[1];
  assign out_drop_word  = out_if.valid && out_if.dropped;
  assign out_no_fin     = (out_if.finished_count == 5'd0);

  `PTLQ_ASSERT_SAME(a_empty_status, out_empty_word, out_zero_head, "empty word not zeroed")
  `PTLQ_ASSERT_SAME(a_blocking_needs_entry, out_blk_word, out_blk_ok, "blocking without head")
  `PTLQ_ASSERT_SAME(a_drop_no_pop, out_drop_word, out_no_fin, "drop and pops in one word")
  `PTLQ_ASSERT_NEXT(a_one_in_flight, in_acc, !in_if.ready, "second word taken in flight")

endmodule
